### rtl/dssr_pkg.sv
// shared types and constants of the dual stepper speed ramp
package dssr_pkg;

   localparam int ACCEL_W     = 15;
   localparam int RATE_W      = 16;
   localparam int PERIOD_W    = 21;
   localparam int QUOT_BITS   = 21;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam int unsigned PCT_SCALE      = 100;
   localparam int unsigned HALF_SECOND_US = 500000;

   localparam logic [PERIOD_W-1:0] STOP_PERIOD = 21'd2000000;

   localparam logic [1:0] REG_ACCEL_LIMIT     = 2'd0;
   localparam logic [1:0] REG_FULL_SCALE_RATE = 2'd1;
   localparam logic [1:0] REG_MIN_RATE        = 2'd2;

   localparam logic [ACCEL_W-1:0] ACCEL_LIMIT_RESET     = 15'd256;
   localparam logic [RATE_W-1:0]  FULL_SCALE_RATE_RESET = 16'd6000;
   localparam logic [RATE_W-1:0]  MIN_RATE_RESET        = 16'd10;

   typedef struct packed {
      logic [ACCEL_W-1:0] accel_limit;
      logic [RATE_W-1:0]  full_scale_rate;
      logic [RATE_W-1:0]  min_rate;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_CHECK,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

### rtl/dssr_queue.sv
// small register queue between the ramp front end and the period back end
module dssr_queue
   import dssr_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/dssr_front.sv
// front end: accepts targets, ramps the current speeds, queues direction and magnitude
module dssr_front
   import dssr_pkg::*;
#(
   parameter int SPEED_WIDTH = 16,
   parameter int FRAC_BITS   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SPEED_WIDTH-1:0]       req_target_left,
   input  logic signed [SPEED_WIDTH-1:0]       req_target_right,
   input  logic [ACCEL_W-1:0]                  accel_limit,
   input  logic                                queue_full,
   output logic                                push,
   output logic [2+2*$clog2((PCT_SCALE << FRAC_BITS) + 1)-1:0] push_data
);

   localparam int unsigned FULL_PCT = PCT_SCALE << FRAC_BITS;
   localparam int MW = $clog2(FULL_PCT + 1);
   localparam int SW = SPEED_WIDTH;
   localparam int RW = SW + ACCEL_W + 2;
   localparam int CW = ((SW > MW) ? SW : MW) + 1;

   logic signed [SW-1:0] speed_left_ff, speed_left_in;
   logic signed [SW-1:0] speed_right_ff, speed_right_in;
   logic                 both_zero;

   function automatic logic signed [SW-1:0] ramp_step(input logic signed [SW-1:0] now,
                                                      input logic signed [SW-1:0] tgt,
                                                      input logic [ACCEL_W-1:0] lim);
      logic signed [RW-1:0] now_x;
      logic signed [RW-1:0] tgt_x;
      logic signed [RW-1:0] lim_x;
      logic signed [RW-1:0] delta;
      logic signed [RW-1:0] res;
      now_x = RW'(now);
      tgt_x = RW'(tgt);
      lim_x = $signed(RW'(lim));
      delta = tgt_x - now_x;
      if (delta > lim_x) begin
         res = now_x + lim_x;
      end else if (delta < -lim_x) begin
         res = now_x - lim_x;
      end else begin
         res = tgt_x;
      end
      return res[SW-1:0];
   endfunction

   function automatic logic [MW-1:0] clamp_mag(input logic signed [SW-1:0] s);
      logic [SW-1:0] raw;
      logic [SW-1:0] a;
      logic [CW-1:0] ax;
      raw = s;
      a   = raw[SW-1] ? (~raw + 1'b1) : raw;
      ax  = CW'(a);
      if (ax > CW'(FULL_PCT)) begin
         return MW'(FULL_PCT);
      end
      return ax[MW-1:0];
   endfunction

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;
   assign both_zero = (req_target_left == '0) && (req_target_right == '0);

   always_comb begin
      if (both_zero) begin
         speed_left_in  = '0;
         speed_right_in = '0;
      end else begin
         speed_left_in  = ramp_step(speed_left_ff, req_target_left, accel_limit);
         speed_right_in = ramp_step(speed_right_ff, req_target_right, accel_limit);
      end
   end

   assign push_data = {!speed_left_in[SW-1], !speed_right_in[SW-1],
                       clamp_mag(speed_left_in), clamp_mag(speed_right_in)};

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_left_ff  <= '0;
         speed_right_ff <= '0;
      end else if (push) begin
         speed_left_ff  <= speed_left_in;
         speed_right_ff <= speed_right_in;
      end
   end

endmodule

### rtl/dssr_back.sv
// back end: step rate product, stop check and shared restoring divider for both sides
module dssr_back
   import dssr_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_valid,
   input  logic [2+2*$clog2((PCT_SCALE << FRAC_BITS) + 1)-1:0] queue_data,
   output logic                  queue_pop,
   input  cfg_type               cfg,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_dir_left,
   output logic                  rsp_dir_right,
   output logic [PERIOD_W-1:0]   rsp_half_period_left,
   output logic [PERIOD_W-1:0]   rsp_half_period_right
);

   localparam int unsigned FULL_PCT = PCT_SCALE << FRAC_BITS;
   localparam int MW = $clog2(FULL_PCT + 1);
   localparam int PW = MW + RATE_W;
   localparam int DW = PW + QUOT_BITS;
   localparam int CNT_W = $clog2(QUOT_BITS);
   localparam logic [63:0] NUMER_WIDE = 64'(HALF_SECOND_US) * 64'(FULL_PCT);
   localparam logic [DW-1:0] NUMER = NUMER_WIDE[DW-1:0];

   back_state_type      state_ff, state_in;
   logic                side_ff, side_in;
   logic                dir_l_ff, dir_l_in, dir_r_ff, dir_r_in;
   logic [MW-1:0]       mag_l_ff, mag_l_in, mag_r_ff, mag_r_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [PW-1:0]       thr_ff, thr_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [DW-1:0]       dsh_ff, dsh_in;
   logic [QUOT_BITS-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PERIOD_W-1:0] per_l_ff, per_l_in, per_r_ff, per_r_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_dir_l_ff, rsp_dir_r_ff;
   logic [PERIOD_W-1:0] rsp_per_l_ff, rsp_per_r_ff;

   logic                stop_case;
   logic                div_ge;
   logic [QUOT_BITS-1:0] quo_next;
   logic [PERIOD_W-1:0] per_div;
   logic                out_free;
   logic                out_load;
   logic [MW-1:0]       mag_sel;

   assign mag_sel   = side_ff ? mag_r_ff : mag_l_ff;
   assign stop_case = (prod_ff == '0) || (prod_ff < thr_ff) ||
                      (NUMER >= {prod_ff, QUOT_BITS'(0)});
   assign div_ge    = (rem_ff >= dsh_ff);
   assign quo_next  = {quo_ff[QUOT_BITS-2:0], div_ge};
   assign per_div   = (quo_next > STOP_PERIOD) ? STOP_PERIOD : quo_next;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (queue_valid) begin
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            state_in = BK_CHECK;
         end
         BK_CHECK: begin
            if (stop_case) begin
               state_in = side_ff ? BK_DONE : BK_MUL;
            end else begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (cnt_ff == '0) begin
               state_in = side_ff ? BK_DONE : BK_MUL;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      queue_pop = 1'b0;
      out_load  = 1'b0;
      side_in   = side_ff;
      dir_l_in  = dir_l_ff;
      dir_r_in  = dir_r_ff;
      mag_l_in  = mag_l_ff;
      mag_r_in  = mag_r_ff;
      prod_in   = prod_ff;
      thr_in    = thr_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      per_l_in  = per_l_ff;
      per_r_in  = per_r_ff;
      case (state_ff)
         BK_IDLE: begin
            if (queue_valid) begin
               queue_pop = 1'b1;
               side_in   = 1'b0;
               {dir_l_in, dir_r_in, mag_l_in, mag_r_in} = queue_data;
            end
         end
         BK_MUL: begin
            prod_in = PW'(mag_sel) * PW'(cfg.full_scale_rate);
            thr_in  = PW'(cfg.min_rate) * PW'(FULL_PCT);
         end
         BK_CHECK: begin
            if (stop_case) begin
               if (side_ff) begin
                  per_r_in = STOP_PERIOD;
               end else begin
                  per_l_in = STOP_PERIOD;
               end
               side_in = 1'b1;
            end else begin
               rem_in = NUMER;
               dsh_in = DW'({prod_ff, (QUOT_BITS - 1)'(0)});
               quo_in = '0;
               cnt_in = CNT_W'(QUOT_BITS - 1);
            end
         end
         BK_DIV: begin
            rem_in = div_ge ? (rem_ff - dsh_ff) : rem_ff;
            dsh_in = dsh_ff >> 1;
            quo_in = quo_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (side_ff) begin
                  per_r_in = per_div;
               end else begin
                  per_l_in = per_div;
               end
               side_in = 1'b1;
            end
         end
         BK_DONE: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_l_ff <= dir_l_in;
      dir_r_ff <= dir_r_in;
      mag_l_ff <= mag_l_in;
      mag_r_ff <= mag_r_in;
      prod_ff  <= prod_in;
      thr_ff   <= thr_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      per_l_ff <= per_l_in;
      per_r_ff <= per_r_in;
      if (out_load) begin
         rsp_dir_l_ff <= dir_l_ff;
         rsp_dir_r_ff <= dir_r_ff;
         rsp_per_l_ff <= per_l_ff;
         rsp_per_r_ff <= per_r_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_dir_left          = rsp_dir_l_ff;
   assign rsp_dir_right         = rsp_dir_r_ff;
   assign rsp_half_period_left  = rsp_per_l_ff;
   assign rsp_half_period_right = rsp_per_r_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while a beat waits");

   a_period_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_per_l_ff <= STOP_PERIOD && rsp_per_r_ff <= STOP_PERIOD))
      else $error("half period above stop period");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV && state_in != BK_DIV) |-> (cnt_ff == '0))
      else $error("divider left before its last step");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      queue_pop |=> (state_ff == BK_MUL && side_ff == 1'b0))
      else $error("popped entry not started on the left side");

endmodule

### rtl/dual_stepper_speed_ramp_top.sv
// top level of the dual stepper speed ramp with its configuration registers
//
//  channel  | direction | handshake              | beat
//  req_     | in        | req_valid / req_ready  | target_left, target_right
//  rsp_     | out       | rsp_valid / rsp_ready  | dir and half period, both sides
//  csr_     | in        | apb, pready tied high  | accel_limit, full_scale_rate, min_rate
//
//  in the back end each item gets two passes of a 21-step restoring divider,
//  one per side, each after a multiply and a check state
//  stopped sides skip their divider pass; the front end ramps in the accept cycle
//  a two-entry queue lets the front accept while the back end works or stalls
//  reset is synchronous and clears speeds, queue, registers and result valid
module dual_stepper_speed_ramp_top
   import dssr_pkg::*;
#(
   parameter int SPEED_WIDTH = 16,
   parameter int FRAC_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SPEED_WIDTH-1:0] req_target_left,
   input  logic signed [SPEED_WIDTH-1:0] req_target_right,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_dir_left,
   output logic                          rsp_dir_right,
   output logic [PERIOD_W-1:0]           rsp_half_period_left,
   output logic [PERIOD_W-1:0]           rsp_half_period_right,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   localparam int MW = $clog2((PCT_SCALE << FRAC_BITS) + 1);
   localparam int EW = 2 + 2 * MW;

   cfg_type         cfg_ff, cfg_in;
   logic            csr_write;
   logic [1:0]      csr_index;
   logic            queue_full;
   logic            push;
   logic [EW-1:0]   push_data;
   logic            queue_pop;
   logic            queue_valid;
   logic [EW-1:0]   queue_data;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_ACCEL_LIMIT:     cfg_in.accel_limit     = csr_pwdata[ACCEL_W-1:0];
            REG_FULL_SCALE_RATE: cfg_in.full_scale_rate = csr_pwdata[RATE_W-1:0];
            REG_MIN_RATE:        cfg_in.min_rate        = csr_pwdata[RATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ACCEL_LIMIT:     csr_prdata = CSR_DATA_W'(cfg_ff.accel_limit);
         REG_FULL_SCALE_RATE: csr_prdata = CSR_DATA_W'(cfg_ff.full_scale_rate);
         REG_MIN_RATE:        csr_prdata = CSR_DATA_W'(cfg_ff.min_rate);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_limit     <= ACCEL_LIMIT_RESET;
         cfg_ff.full_scale_rate <= FULL_SCALE_RATE_RESET;
         cfg_ff.min_rate        <= MIN_RATE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dssr_front #(
      .SPEED_WIDTH (SPEED_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_target_left  (req_target_left),
      .req_target_right (req_target_right),
      .accel_limit      (cfg_ff.accel_limit),
      .queue_full       (queue_full),
      .push             (push),
      .push_data        (push_data)
   );

   dssr_queue #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_valid (queue_valid),
      .pop_data  (queue_data)
   );

   dssr_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .queue_valid           (queue_valid),
      .queue_data            (queue_data),
      .queue_pop             (queue_pop),
      .cfg                   (cfg_ff),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_dir_left          (rsp_dir_left),
      .rsp_dir_right         (rsp_dir_right),
      .rsp_half_period_left  (rsp_half_period_left),
      .rsp_half_period_right (rsp_half_period_right)
   );

endmodule

### verif/testbench.sv
// self-checking testbench for dual_stepper_speed_ramp_top
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dssr_pkg::*;

   localparam int     SPD_W         = 16;
   localparam int     FRAC          = 8;
   localparam longint FULL_PCT      = longint'(PCT_SCALE) << FRAC;
   localparam int     CYCLE_LIMIT   = 900000;
   localparam int     SETTLE_CYCLES = 60;
   localparam int     DIRECTED_N    = 21;
   localparam int     DIRECTED_FAST = 8;

   localparam logic [1:0] REG_PAST_END = 2'd3;

   typedef logic signed [SPD_W-1:0] speed_t;

   typedef struct packed {
      logic                dir_left;
      logic                dir_right;
      logic [PERIOD_W-1:0] period_left;
      logic [PERIOD_W-1:0] period_right;
   } motor_beat_t;

   typedef enum {
      STALL_NONE,
      STALL_RANDOM,
      STALL_BURST,
      STALL_TOGGLE
   } stall_mode_t;

   localparam speed_t DIRECTED_LEFT [DIRECTED_N] = '{
      0, 1, 256, 1000, 0, 0, 32767, -32768,
      32767, 32767, -32768, 25600, 25601, 43, 42, -1, 0, 25600, 0, -32768, 0};
   localparam speed_t DIRECTED_RIGHT [DIRECTED_N] = '{
      0, -1, -256, -1000, 300, 0, -32768, 32767,
      -32768, -32768, 32767, -25600, -25599, -43, -42, 1, 25600, 0, 0, -32768, 0};

   class ramp_scoreboard;
      logic [ACCEL_W-1:0] accel_limit;
      logic [RATE_W-1:0]  full_scale_rate;
      logic [RATE_W-1:0]  min_rate;
      speed_t             speed_left;
      speed_t             speed_right;
      motor_beat_t        expected_beats[$];
      int                 mismatches;
      int                 beats_checked;
      int                 targets_taken;
      int                 stopped_seen;
      int                 saturated_seen;

      function new();
         accel_limit     = ACCEL_LIMIT_RESET;
         full_scale_rate = FULL_SCALE_RATE_RESET;
         min_rate        = MIN_RATE_RESET;
         speed_left      = '0;
         speed_right     = '0;
         mismatches      = 0;
         beats_checked   = 0;
         targets_taken   = 0;
         stopped_seen    = 0;
         saturated_seen  = 0;
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%s", msg);
         end
      endfunction

      function void write_reg(logic [1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_ACCEL_LIMIT:     accel_limit = value[ACCEL_W-1:0];
            REG_FULL_SCALE_RATE: full_scale_rate = value[RATE_W-1:0];
            REG_MIN_RATE:        min_rate = value[RATE_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_W-1:0] reg_value(logic [1:0] index);
         case (index)
            REG_ACCEL_LIMIT:     return CSR_DATA_W'(accel_limit);
            REG_FULL_SCALE_RATE: return CSR_DATA_W'(full_scale_rate);
            REG_MIN_RATE:        return CSR_DATA_W'(min_rate);
            default:             return '0;
         endcase
      endfunction

      function speed_t ramp_toward(speed_t now, speed_t target);
         longint delta;
         longint lim;
         delta = longint'(target) - longint'(now);
         lim   = longint'(accel_limit);
         if (delta > lim) return speed_t'(longint'(now) + lim);
         if (delta < -lim) return speed_t'(longint'(now) - lim);
         return target;
      endfunction

      function logic [PERIOD_W-1:0] half_period_us(speed_t spd);
         longint mag;
         longint prod;
         longint per;
         mag = longint'(spd);
         if (mag < 0) mag = -mag;
         if (mag > FULL_PCT) mag = FULL_PCT;
         prod = mag * longint'(full_scale_rate);
         if (prod == 0 || prod < longint'(min_rate) * FULL_PCT) begin
            stopped_seen++;
            return STOP_PERIOD;
         end
         per = longint'(HALF_SECOND_US) * FULL_PCT / prod;
         if (per > longint'(STOP_PERIOD)) begin
            saturated_seen++;
            per = longint'(STOP_PERIOD);
         end
         return per[PERIOD_W-1:0];
      endfunction

      function void note_target(speed_t tl, speed_t tr);
         motor_beat_t beat;
         targets_taken++;
         if (tl == 0 && tr == 0) begin
            speed_left  = '0;
            speed_right = '0;
         end else begin
            speed_left  = ramp_toward(speed_left, tl);
            speed_right = ramp_toward(speed_right, tr);
         end
         beat.dir_left     = (speed_left >= 0);
         beat.dir_right    = (speed_right >= 0);
         beat.period_left  = half_period_us(speed_left);
         beat.period_right = half_period_us(speed_right);
         expected_beats.push_back(beat);
      endfunction

      function void check_result(logic dl, logic dr, logic [PERIOD_W-1:0] pl,
                                 logic [PERIOD_W-1:0] pr);
         motor_beat_t want;
         beats_checked++;
         if (expected_beats.size() == 0) begin
            report($sformatf("result beat %0d arrived with no target pending", beats_checked));
            return;
         end
         want = expected_beats.pop_front();
         if (dl !== want.dir_left)
            report($sformatf("beat %0d dir_left: expected %0b, got %0b",
                             beats_checked, want.dir_left, dl));
         if (dr !== want.dir_right)
            report($sformatf("beat %0d dir_right: expected %0b, got %0b",
                             beats_checked, want.dir_right, dr));
         if (pl !== want.period_left)
            report($sformatf("beat %0d half_period_left: expected %0d, got %0d",
                             beats_checked, want.period_left, pl));
         if (pr !== want.period_right)
            report($sformatf("beat %0d half_period_right: expected %0d, got %0d",
                             beats_checked, want.period_right, pr));
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   speed_t                req_target_left = '0;
   speed_t                req_target_right = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_dir_left;
   logic                  rsp_dir_right;
   logic [PERIOD_W-1:0]   rsp_half_period_left;
   logic [PERIOD_W-1:0]   rsp_half_period_right;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ramp_scoreboard board = new();
   stall_mode_t    stall_mode = STALL_NONE;
   int             stall_timer = 0;
   int             hold_left = 0;
   int             cycle_count = 0;
   int             settings_used = 1;

   dual_stepper_speed_ramp_top dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // result side: check the beat, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_dir_left, rsp_dir_right,
                            rsp_half_period_left, rsp_half_period_right);
      end
      if (stall_timer == 0) begin
         stall_mode  = stall_mode_t'($urandom_range(0, 3));
         stall_timer = $urandom_range(50, 400);
      end else begin
         stall_timer--;
      end
      case (stall_mode)
         STALL_NONE:   rsp_ready <= 1'b1;
         STALL_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         STALL_BURST: begin
            if (hold_left > 0) begin
               hold_left--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
               hold_left = $urandom_range(1, 40);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
         default: rsp_ready <= ~rsp_ready;
      endcase
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("dual_stepper_speed_ramp_top regression: fail");
      $finish;
   end

   task automatic send_target(input speed_t tl, input speed_t tr);
      req_valid        <= 1'b1;
      req_target_left  <= tl;
      req_target_right <= tr;
      do @(posedge clock); while (!(req_valid && req_ready));
      board.note_target(tl, tr);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.write_reg(index, value);
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [1:0] index);
      logic [CSR_DATA_W-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      want = board.reg_value(index);
      if (csr_prdata !== want) begin
         board.report($sformatf("register %0d readback: expected %0d, got %0d",
                                index, want, csr_prdata));
      end
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // registers change only with nothing in flight
   task automatic program_setting(input int accel, input int fsr, input int minr);
      logic [CSR_DATA_W-1:0] junk;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      junk = $urandom_range(0, 1) ? $urandom() : '0;
      csr_write(REG_ACCEL_LIMIT, (junk << ACCEL_W) | CSR_DATA_W'(accel));
      junk = $urandom_range(0, 1) ? $urandom() : '0;
      csr_write(REG_FULL_SCALE_RATE, (junk << RATE_W) | CSR_DATA_W'(fsr));
      junk = $urandom_range(0, 1) ? $urandom() : '0;
      csr_write(REG_MIN_RATE, (junk << RATE_W) | CSR_DATA_W'(minr));
      csr_check(REG_ACCEL_LIMIT);
      csr_check(REG_FULL_SCALE_RATE);
      csr_check(REG_MIN_RATE);
      settings_used++;
   endtask

   function automatic speed_t next_target(speed_t prev);
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2:    return prev;
         3:       return speed_t'(int'($urandom_range(0, 400)) - 200);
         4:       return speed_t'(($urandom_range(0, 1) ? 1 : -1) *
                                  (25500 + int'($urandom_range(0, 200))));
         7:       return $urandom_range(0, 1) ? speed_t'(32767) : speed_t'(-32768);
         8, 9:    return speed_t'(int'(prev) + int'($urandom_range(0, 2000)) - 1000);
         default: return speed_t'($urandom());
      endcase
   endfunction

   task automatic run_phase(input int accel, input int fsr, input int minr, input int count);
      int     sent;
      int     burst;
      speed_t tl;
      speed_t tr;
      program_setting(accel, fsr, minr);
      sent = 0;
      tl   = '0;
      tr   = '0;
      while (sent < count) begin
         burst = $urandom_range(1, 30);
         while (burst > 0 && sent < count) begin
            if ($urandom_range(0, 11) == 0) begin
               tl = '0;
               tr = '0;
            end else begin
               tl = next_target(tl);
               tr = next_target(tr);
            end
            send_target(tl, tr);
            sent++;
            burst--;
         end
         if (sent < count) begin
            case ($urandom_range(0, 9))
               0, 1, 2: ;
               8:       idle_sender($urandom_range(13, 80));
               9:       drain_results();
               default: idle_sender($urandom_range(1, 12));
            endcase
         end
      end
   endtask

   initial begin
      int accel_pick;
      int fsr_pick;
      int minr_pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed beats: slow ramp at reset values, then full-range acceleration
      for (int i = 0; i < DIRECTED_N; i++) begin
         if (i == DIRECTED_FAST) begin
            program_setting(25600, FULL_SCALE_RATE_RESET, MIN_RATE_RESET);
            csr_write(REG_PAST_END, $urandom());
            csr_check(REG_ACCEL_LIMIT);
            csr_check(REG_FULL_SCALE_RATE);
            csr_check(REG_MIN_RATE);
         end
         send_target(DIRECTED_LEFT[i], DIRECTED_RIGHT[i]);
      end

      run_phase(ACCEL_LIMIT_RESET, FULL_SCALE_RATE_RESET, MIN_RATE_RESET, 150);
      run_phase(25600, 65535, 1, 120);
      run_phase(1, 1, 1, 60);
      run_phase(25600, 65535, 65535, 80);
      run_phase(1, 65535, 1, 80);
      repeat (5) begin
         accel_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                  : $urandom_range(1, 25600);
         fsr_pick   = $urandom_range(1, 65535);
         minr_pick  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                  : $urandom_range(1, 300);
         run_phase(accel_pick, fsr_pick, minr_pick, 130);
      end
      // zero min rate lets long periods saturate
      run_phase(25600, 6000, 0, 60);
      // zero acceleration: only the both-zero stop moves the speeds
      run_phase(0, 6000, 10, 40);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d targets sent, %0d result beats checked under %0d register settings",
               board.targets_taken, board.beats_checked, settings_used);
      $display("%0d side periods at the stop value, %0d saturated, %0d mismatches",
               board.stopped_seen, board.saturated_seen, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("dual_stepper_speed_ramp_top regression: pass");
      end else begin
         $display("dual_stepper_speed_ramp_top regression: fail");
      end
      $finish;
   end

endmodule
